[rtl/hbd_pkg.sv]
package hbd_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int LINE_W           = SAMPLE_W + 1;
  localparam int COEF_W           = 18;
  localparam int COEF_FRAC        = COEF_W - 1;
  localparam int OUT_W            = 18;
  localparam int OUT_FRAC         = 16;
  localparam int REAL_DELAY_DEPTH = 13;
  localparam int REAL_TAP         = REAL_DELAY_DEPTH - 2;
  localparam int IMAG_TAPS        = 24;
  localparam int HALF_TAPS        = IMAG_TAPS / 2;
  localparam int PROD_W           = LINE_W + COEF_W;
  localparam int ACC_W            = PROD_W + 1;
  localparam int ACC_FRAC         = COEF_FRAC + SAMPLE_W - 1;
  localparam int RND_SHIFT        = ACC_FRAC - OUT_FRAC;
  localparam int Q_W              = ACC_W - RND_SHIFT;

  typedef logic signed [LINE_W-1:0] line_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic signed [Q_W-1:0]    q_t;

  localparam acc_t ACC_RND = acc_t'(1) <<< (RND_SHIFT - 1);
  localparam q_t   Q_MAX   = (q_t'(1) <<< (OUT_W - 1)) - q_t'(1);
  localparam q_t   Q_MIN   = -(q_t'(1) <<< (OUT_W - 1));

  // halfband coefficients in Q1.17, center tap outward, signs applied
  localparam coef_t HB_COEF [HALF_TAPS] = '{
    coef_t'(82648), -coef_t'(25511), coef_t'(13107), -coef_t'(7390),
    coef_t'(4162),  -coef_t'(2245),  coef_t'(1128),  -coef_t'(514),
    coef_t'(206),   -coef_t'(69),    coef_t'(18),    -coef_t'(3)
  };

  function automatic coef_t tap_coef(input int j);
    int k;
    k = (j < HALF_TAPS) ? (HALF_TAPS - 1 - j) : (j - HALF_TAPS);
    return HB_COEF[k];
  endfunction

endpackage

[rtl/hbd_delay_cell.sv]
module hbd_delay_cell import hbd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  line_t d,
  output line_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

[rtl/hbd_mac_cell.sv]
module hbd_mac_cell import hbd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  line_t x,
  input  coef_t coef,
  input  acc_t  sum_in,
  output acc_t  sum_q
);

  logic signed [PROD_W-1:0] prod;
  acc_t                     sum_next;

  assign prod     = PROD_W'(x) * PROD_W'(coef);
  assign sum_next = sum_in + acc_t'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_q <= '0;
    end else if (en) begin
      sum_q <= sum_next;
    end
  end

endmodule

[rtl/halfband_fs4_ddc_decimate2.sv]
// halfband_fs4_ddc_decimate2: fs/4 down-converter with halfband decimation by two
// throughput: one sample item per cycle unless in_stall holds it; one result item per two sample items
// each odd-bank sample item's result is held pending, then registered to the outputs once they are free
// the transposed filter is a chain of 24 multiply-add cells, one product each
// reset (synchronous): lines and partial sums cleared, real bank first,
// conj_keep set to 1
module halfband_fs4_ddc_decimate2 import hbd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_t                       out_real,
  output out_t                       out_imag,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);

  logic  conj_keep;
  logic  bank_select;
  logic  real_sign;
  logic  imag_sign;
  logic  p1_valid;
  out_t  held_real;
  logic  in_accept;
  logic  real_en;
  logic  imag_en;
  logic  out_free;
  logic  flip;
  line_t s_ext;
  line_t x;
  line_t rline [REAL_TAP+1];
  acc_t  chain [IMAG_TAPS+1];
  acc_t  acc_adj;
  acc_t  acc_rnd;
  q_t    acc_q;
  out_t  imag_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = p1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign real_en   = in_accept && !bank_select;
  assign imag_en   = in_accept && bank_select;

  assign flip  = bank_select ? imag_sign : real_sign;
  assign s_ext = line_t'(sample);
  assign x     = flip ? -s_ext : s_ext;

  // real bank delay line
  genvar j;
  generate
    for (j = 0; j <= REAL_TAP; j++) begin : g_real
      hbd_delay_cell u_dly (
        .clk (clk),
        .rst (rst),
        .en  (real_en),
        .d   ((j == 0) ? x : rline[(j == 0) ? 0 : j - 1]),
        .q   (rline[j])
      );
    end
  endgenerate

  // transposed halfband, partial sums pass toward cell 0
  assign chain[IMAG_TAPS] = '0;

  generate
    for (j = 0; j < IMAG_TAPS; j++) begin : g_tap
      hbd_mac_cell u_mac (
        .clk    (clk),
        .rst    (rst),
        .en     (imag_en),
        .x      (x),
        .coef   (tap_coef(j)),
        .sum_in (chain[j+1]),
        .sum_q  (chain[j])
      );
    end
  endgenerate

  // negate unless conj_keep is set, round half up, then saturate
  always_comb begin
    acc_adj = conj_keep ? chain[0] : -chain[0];
    acc_rnd = acc_adj + ACC_RND;
    acc_q   = acc_rnd[ACC_W-1:RND_SHIFT];
    if (acc_q > Q_MAX) begin
      imag_next = Q_MAX[OUT_W-1:0];
    end else if (acc_q < Q_MIN) begin
      imag_next = Q_MIN[OUT_W-1:0];
    end else begin
      imag_next = acc_q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conj_keep   <= 1'b1;
      bank_select <= 1'b0;
      real_sign   <= 1'b0;
      imag_sign   <= 1'b0;
      p1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        conj_keep <= cfg_data;
      end
      if (in_accept) begin
        bank_select <= !bank_select;
      end
      if (real_en) begin
        real_sign <= !real_sign;
      end
      if (imag_en) begin
        imag_sign <= !imag_sign;
        p1_valid  <= 1'b1;
      end else if (out_free) begin
        p1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (imag_en) begin
      held_real <= {rline[REAL_TAP], 1'b0};
    end
    if (out_free && p1_valid) begin
      out_real <= held_real;
      out_imag <= imag_next;
    end
  end

  a_real_no_result: assert property (@(posedge clk) disable iff (rst)
    real_en |=> !p1_valid)
    else $error("real bank item left a pending result");

  a_imag_result: assert property (@(posedge clk) disable iff (rst)
    imag_en |=> p1_valid)
    else $error("imag bank item produced no pending result");

  a_bank_toggle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> bank_select != $past(bank_select))
    else $error("bank select did not alternate");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    p1_valid && out_valid && out_stall |-> in_stall)
    else $error("item accepted while pipeline full");

endmodule
